/* rtl/core/sssd_pkg.sv */
// Package for the seven-segment scan driver: constants, digit types and segment decode.
`default_nettype none
package sssd_pkg;

    localparam int VALUE_W = 16;
    localparam int SEG_W   = 8;
    localparam int DIGITS  = 4;

    localparam logic [VALUE_W-1:0] LIMIT_VALUE   = 16'd9999;
    localparam logic [SEG_W-1:0]   ERROR_PATTERN = 8'h86;
    localparam logic [DIGITS-1:0]  ALL_OFF       = 4'hF;
    localparam logic [DIGITS-1:0]  ALL_ON        = 4'h0;

    // Scan position codes, leftmost digit first
    localparam logic [1:0] POS_THOUSANDS = 2'd0;
    localparam logic [1:0] POS_HUNDREDS  = 2'd1;
    localparam logic [1:0] POS_TENS      = 2'd2;
    localparam logic [1:0] POS_UNITS     = 2'd3;

    // Reciprocal constants for the digit split (valid for inputs up to 9999)
    localparam logic [13:0] RECIP_1000 = 14'd8389;  // / 2^23
    localparam logic [5:0]  RECIP_100  = 6'd41;     // / 2^12
    localparam logic [7:0]  RECIP_10   = 8'd205;    // / 2^11

    typedef struct packed {
        logic [3:0] thousands;
        logic [3:0] hundreds;
        logic [3:0] tens;
        logic [3:0] units;
    } digits_t;

    function automatic logic [SEG_W-1:0] seg_decode(input logic [3:0] digit);
        logic [SEG_W-1:0] seg;
        unique case (digit)
            4'd0:    seg = 8'hC0;
            4'd1:    seg = 8'hF9;
            4'd2:    seg = 8'hA4;
            4'd3:    seg = 8'hB0;
            4'd4:    seg = 8'h99;
            4'd5:    seg = 8'h92;
            4'd6:    seg = 8'h82;
            4'd7:    seg = 8'hF8;
            4'd8:    seg = 8'h80;
            4'd9:    seg = 8'h90;
            default: seg = 8'hC0;
        endcase
        return seg;
    endfunction

endpackage
`default_nettype wire

/* rtl/core/seven_segment_scan_driver_unit.sv */
// Four-digit seven-segment scan driver: top level.
// An accepted value is held in the input register and then in the result register.
// Throughput: one value per cycle while m_ready holds; the input register refills while a result waits.
// Digit split, blanking and decode sit between the input and result registers.
// Reset (aresetn low, synchronous) empties both registers, sets scan to the
// leftmost digit and clears the leading-blank flag.
`default_nettype none
module seven_segment_scan_driver_unit (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [sssd_pkg::VALUE_W-1:0]        s_value,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic      [sssd_pkg::SEG_W-1:0]          m_segments,
    output logic      [sssd_pkg::DIGITS-1:0]         m_digit_enables,
    output logic                                     m_overflow
);
    import sssd_pkg::*;

    logic                  in_valid_reg;
    logic [VALUE_W-1:0]    value_reg;
    logic                  out_valid_reg;
    logic [SEG_W-1:0]      seg_reg,  seg_next;
    logic [DIGITS-1:0]     en_reg,   en_next;
    logic                  ovf_reg,  ovf_next;
    logic [1:0]            scan_pos_reg,   scan_pos_next;
    logic                  lead_blank_reg, lead_blank_next;

    logic                  advance;
    digits_t               digits;
    logic [3:0]            digit;
    logic                  show;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    sssd_digit_split u_split (
        .value  (value_reg),
        .digits (digits)
    );

    always_comb begin
        unique case (scan_pos_reg)
            POS_THOUSANDS: digit = digits.thousands;
            POS_HUNDREDS:  digit = digits.hundreds;
            POS_TENS:      digit = digits.tens;
            POS_UNITS:     digit = digits.units;
            default:       digit = digits.units;
        endcase
    end

    always_comb begin
        show            = 1'b1;
        lead_blank_next = lead_blank_reg;
        scan_pos_next   = scan_pos_reg;
        seg_next        = ERROR_PATTERN;
        en_next         = ALL_ON;
        ovf_next        = 1'b1;
        if (value_reg <= LIMIT_VALUE) begin
            unique case (scan_pos_reg)
                POS_THOUSANDS: begin
                    show            = (digit != 4'd0);
                    lead_blank_next = (digit == 4'd0);
                end
                POS_UNITS: begin
                    show            = 1'b1;
                    lead_blank_next = 1'b0;
                end
                default: begin
                    show = !((digit == 4'd0) && lead_blank_reg);
                    if (digit != 4'd0) begin
                        lead_blank_next = 1'b0;
                    end
                end
            endcase
            scan_pos_next = scan_pos_reg + 2'd1;
            seg_next      = seg_decode(digit);
            // Active-low enable for the current position only
            en_next       = show ? ~(DIGITS'(1) << scan_pos_reg) : ALL_OFF;
            ovf_next      = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            scan_pos_reg   <= POS_THOUSANDS;
            lead_blank_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg  <= 1'b1;
                scan_pos_reg   <= scan_pos_next;
                lead_blank_reg <= lead_blank_next;
            end else if (m_ready) begin
                out_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            value_reg <= s_value;
        end
        if (advance) begin
            seg_reg <= seg_next;
            en_reg  <= en_next;
            ovf_reg <= ovf_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_segments      = seg_reg;
    assign m_digit_enables = en_reg;
    assign m_overflow      = ovf_reg;

endmodule
`default_nettype wire

/* rtl/core/sssd_digit_split.sv */
// Splits an in-range value into four decimal digits by reciprocal multiplication.
`default_nettype none
module sssd_digit_split (
    input  wire logic [sssd_pkg::VALUE_W-1:0] value,
    output sssd_pkg::digits_t                 digits
);
    import sssd_pkg::*;

    logic [13:0] v;
    logic [27:0] prod_1000;
    logic [3:0]  q_1000;
    logic [13:0] rem_1000_full;
    logic [9:0]  rem_1000;
    logic [15:0] prod_100;
    logic [3:0]  q_100;
    logic [9:0]  rem_100_full;
    logic [6:0]  rem_100;
    logic [14:0] prod_10;
    logic [3:0]  q_10;
    logic [6:0]  rem_10_full;

    // Only the low 14 bits matter: anything above 9999 is flagged elsewhere
    assign v = value[13:0];

    assign prod_1000     = 28'(v) * 28'(RECIP_1000);
    assign q_1000        = prod_1000[26:23];
    assign rem_1000_full = v - 14'(q_1000) * 14'd1000;
    assign rem_1000      = rem_1000_full[9:0];

    assign prod_100     = 16'(rem_1000) * 16'(RECIP_100);
    assign q_100        = prod_100[15:12];
    assign rem_100_full = rem_1000 - 10'(q_100) * 10'd100;
    assign rem_100      = rem_100_full[6:0];

    assign prod_10     = 15'(rem_100) * 15'(RECIP_10);
    assign q_10        = prod_10[14:11];
    assign rem_10_full = rem_100 - 7'(q_10) * 7'd10;

    assign digits.thousands = q_1000;
    assign digits.hundreds  = q_100;
    assign digits.tens      = q_10;
    assign digits.units     = rem_10_full[3:0];

endmodule
`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps
// Testbench for the seven-segment scan driver: directed table, random scan sweeps, scoreboard.
module tb;
    import sssd_pkg::*;

    typedef struct packed {
        logic [SEG_W-1:0]  segments;
        logic [DIGITS-1:0] enables;
        logic              overflow;
    } tick_out_t;

    typedef struct {
        logic [VALUE_W-1:0] value;
        bit                 typed;
        tick_out_t          result;
    } dir_row_t;

    localparam int DIR_ROWS    = 24;
    localparam int RAND_ITEMS  = 950;
    localparam int HOLD_AFTER  = 200;
    localparam int HOLD_CYCLES = 80;

    localparam tick_out_t UNTYPED    = '0;
    localparam tick_out_t ZERO_BLANK = '{8'hC0, ALL_OFF, 1'b0};
    localparam tick_out_t OVF_SHOWN  = '{ERROR_PATTERN, ALL_ON, 1'b1};
    localparam tick_out_t NINE_LEFT  = '{8'h90, 4'hE, 1'b0};

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [VALUE_W-1:0]  s_value;
    logic                m_valid;
    logic                m_ready;
    logic [SEG_W-1:0]    m_segments;
    logic [DIGITS-1:0]   m_digit_enables;
    logic                m_overflow;

    // predictor state
    logic [1:0]          scan_pos;
    logic                lead_blank;
    logic [SEG_W-1:0]    digit_glyph [10];

    dir_row_t            dir_rows [DIR_ROWS];
    tick_out_t           expected_q [$];
    int                  tx_count;
    int                  rx_count;
    int                  err_count;
    bit                  tx_burst;
    bit                  rx_burst;

    seven_segment_scan_driver_unit u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_value         (s_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_segments      (m_segments),
        .m_digit_enables (m_digit_enables),
        .m_overflow      (m_overflow)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3_000_000;
        $display("tb: failure");
        $finish;
    end

    // One scan tick: returns what the display shows and advances the scan state
    function automatic tick_out_t display_tick(input logic [VALUE_W-1:0] v);
        tick_out_t   r;
        int unsigned d;
        bit          show;
        r.overflow = 1'b0;
        r.enables  = ALL_OFF;
        if (v > LIMIT_VALUE) begin
            // error pattern on all digits, scan holds
            r.segments = ERROR_PATTERN;
            r.enables  = ALL_ON;
            r.overflow = 1'b1;
            return r;
        end
        case (scan_pos)
            POS_THOUSANDS: d = (v / 1000) % 10;
            POS_HUNDREDS:  d = (v / 100) % 10;
            POS_TENS:      d = (v / 10) % 10;
            default:       d = v % 10;
        endcase
        if (scan_pos == POS_THOUSANDS) begin
            show       = (d != 0);
            lead_blank = !show;
        end else if (scan_pos == POS_UNITS) begin
            show       = 1'b1;
            lead_blank = 1'b0;
        end else begin
            show = !(d == 0 && lead_blank);
            if (d != 0) lead_blank = 1'b0;
        end
        if (show) r.enables[scan_pos] = 1'b0;
        scan_pos   = scan_pos + 2'd1;
        r.segments = digit_glyph[d];
        return r;
    endfunction

    task automatic report(input string msg);
        $display("tb: mismatch: %s", msg);
        err_count++;
    endtask

    task automatic send_value(input logic [VALUE_W-1:0] v, input bit typed,
                              input tick_out_t given);
        int        gap;
        tick_out_t want;
        if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        want = display_tick(v);
        expected_q.push_back(typed ? given : want);
        tx_count++;
    endtask

    initial begin : result_sink
        tick_out_t want;
        int        stall;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, 9);
            // long hold-off so the block fills up and backs up the input
            if (rx_count == HOLD_AFTER) stall = HOLD_CYCLES;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            if (expected_q.size() == 0) begin
                report($sformatf("result %0d arrived with nothing expected", rx_count));
            end else begin
                want = expected_q.pop_front();
                if (m_segments !== want.segments)
                    report($sformatf("result %0d segments: expected 0x%0h, got 0x%0h",
                                     rx_count, want.segments, m_segments));
                if (m_digit_enables !== want.enables)
                    report($sformatf("result %0d digit_enables: expected 0x%0h, got 0x%0h",
                                     rx_count, want.enables, m_digit_enables));
                if (m_overflow !== want.overflow)
                    report($sformatf("result %0d overflow: expected %0b, got %0b",
                                     rx_count, want.overflow, m_overflow));
            end
            rx_count++;
        end
    end

    initial begin : stimulus
        logic [VALUE_W-1:0] v;
        int                 cls;
        int                 reps;
        tx_count   = 0;
        rx_count   = 0;
        err_count  = 0;
        tx_burst   = 1'b0;
        rx_burst   = 1'b0;
        scan_pos   = POS_THOUSANDS;
        lead_blank = 1'b0;
        digit_glyph = '{8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90};
        dir_rows = '{
            '{16'd0,     1'b1, ZERO_BLANK},  // leftmost zero after reset is blanked
            '{16'd65535, 1'b1, OVF_SHOWN},
            '{16'd10000, 1'b1, OVF_SHOWN},   // just above the limit, scan holds
            '{16'd0,     1'b0, UNTYPED},
            '{16'd9999,  1'b0, UNTYPED},
            '{16'd0,     1'b0, UNTYPED},
            '{16'd1234,  1'b0, UNTYPED},
            '{16'd1234,  1'b0, UNTYPED},
            '{16'd1234,  1'b0, UNTYPED},
            '{16'd1234,  1'b0, UNTYPED},
            '{16'd5,     1'b0, UNTYPED},     // three leading zeros blanked
            '{16'd5,     1'b0, UNTYPED},
            '{16'd5,     1'b0, UNTYPED},
            '{16'd5,     1'b0, UNTYPED},
            '{16'd50,    1'b0, UNTYPED},     // units zero still shown
            '{16'd50,    1'b0, UNTYPED},
            '{16'd50,    1'b0, UNTYPED},
            '{16'd50,    1'b0, UNTYPED},
            '{16'd500,   1'b0, UNTYPED},     // inner zero after a nonzero digit shown
            '{16'd500,   1'b0, UNTYPED},
            '{16'd500,   1'b0, UNTYPED},
            '{16'd500,   1'b0, UNTYPED},
            '{16'd9999,  1'b1, NINE_LEFT},
            '{16'd10000, 1'b1, OVF_SHOWN}    // error in mid sweep
        };

        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_value <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_value(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].result);

        // mostly whole sweeps of one value; short runs and overflow act as noise
        while (tx_count < DIR_ROWS + RAND_ITEMS) begin
            cls = $urandom_range(0, 99);
            if (cls < 12)      v = $urandom_range(10000, 65535);
            else if (cls < 35) v = $urandom_range(0, 99);
            else if (cls < 55) v = $urandom_range(0, 999);
            else               v = $urandom_range(0, 9999);
            reps = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 4;
            repeat (reps) send_value(v, 1'b0, UNTYPED);
        end
        s_valid <= 1'b0;

        while (expected_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
